// ===== design/two_state_kalman_tracker_core_defines.svh =====
// ----------------------------------------------------------------------------
// two_state_kalman_tracker_core_defines
// Assertion macros used by the checker file of the tracker core.
// ----------------------------------------------------------------------------
`ifndef TWO_STATE_KALMAN_TRACKER_CORE_DEFINES_SVH
`define TWO_STATE_KALMAN_TRACKER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TSKT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define TSKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tskt_pkg.sv =====
// ----------------------------------------------------------------------------
// tskt_pkg
// Types, codes and the micro program of the two-state tracker core.
// ----------------------------------------------------------------------------
package tskt_pkg;

    // arithmetic unit and sequencer opcodes
    typedef enum logic [3:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_DIV,
        OP_CLAMP,
        OP_HALF,
        OP_RNDW,
        OP_RNDT,
        OP_SQRT,
        OP_JOUT,
        OP_END
    } op_t;

    typedef enum logic [2:0] {
        AL_IDLE,
        AL_MUL,
        AL_DIV,
        AL_SQRT,
        AL_FIN
    } alu_state_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_FETCH,
        SQ_ISSUE,
        SQ_WAIT,
        SQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef struct packed {
        logic done;
    } alu_rsp_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [3:0] dst;
    } instr_t;

    // values taken from the input word and the configuration
    typedef struct packed {
        logic [63:0] w;
        logic [63:0] t0;
        logic [63:0] ow;
        logic [63:0] oc;
        logic [63:0] pw;
        logic [63:0] pt;
        logic [63:0] wf;
        logic [63:0] cf;
        logic [63:0] avg;
        logic [63:0] dt;
        logic [63:0] k;
    } spec_t;

    localparam logic [63:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_SMAX = 64'h8000_0000_0000_0001;
    localparam logic [63:0] SMIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] EST_LIM  = 64'h0000_7FFF_FFFF_FFFF;

    localparam logic [15:0] WEIGHT_FLOOR = 16'd3000;
    localparam logic [14:0] CAL_FLOOR    = 15'd1200;

    // configuration register indexes
    localparam logic [2:0] CFG_CAL_PER_FAT_KG    = 3'd0;
    localparam logic [2:0] CFG_OBS_WEIGHT_NOISE  = 3'd1;
    localparam logic [2:0] CFG_OBS_CAL_NOISE     = 3'd2;
    localparam logic [2:0] CFG_PROC_WEIGHT_NOISE = 3'd3;
    localparam logic [2:0] CFG_PROC_TDEE_NOISE   = 3'd4;
    localparam logic [2:0] CFG_INITIAL_TDEE      = 3'd5;

    // register file entries
    localparam logic [4:0] R_EW  = 5'd0;
    localparam logic [4:0] R_ET  = 5'd1;
    localparam logic [4:0] R_VWW = 5'd2;
    localparam logic [4:0] R_VWT = 5'd3;
    localparam logic [4:0] R_VTT = 5'd4;
    localparam logic [4:0] R_A   = 5'd5;
    localparam logic [4:0] R_U   = 5'd6;
    localparam logic [4:0] R_T7  = 5'd7;
    localparam logic [4:0] R_T8  = 5'd8;
    localparam logic [4:0] R_P01 = 5'd9;
    localparam logic [4:0] R_P00 = 5'd10;
    localparam logic [4:0] R_S   = 5'd11;
    localparam logic [4:0] R_K0  = 5'd12;
    localparam logic [4:0] R_K1  = 5'd13;
    localparam logic [4:0] R_WP  = 5'd14;
    localparam logic [4:0] R_DEL = 5'd15;

    // special operand sources
    localparam logic [4:0] SRC_W    = 5'd16;
    localparam logic [4:0] SRC_T0   = 5'd17;
    localparam logic [4:0] SRC_OW   = 5'd18;
    localparam logic [4:0] SRC_OC   = 5'd19;
    localparam logic [4:0] SRC_PW   = 5'd20;
    localparam logic [4:0] SRC_PT   = 5'd21;
    localparam logic [4:0] SRC_WF   = 5'd22;
    localparam logic [4:0] SRC_CF   = 5'd23;
    localparam logic [4:0] SRC_AVG  = 5'd24;
    localparam logic [4:0] SRC_DT   = 5'd25;
    localparam logic [4:0] SRC_K    = 5'd26;
    localparam logic [4:0] SRC_ZERO = 5'd27;

    // result field slots
    localparam logic [4:0] OUT_EW  = 5'd0;
    localparam logic [4:0] OUT_ET  = 5'd1;
    localparam logic [4:0] OUT_SDW = 5'd2;
    localparam logic [4:0] OUT_SDT = 5'd3;

    localparam logic [5:0] STEP_START = 6'd14;
    localparam logic [5:0] OUT_START  = 6'd56;

    function automatic instr_t ins(op_t op, logic [4:0] a, logic [4:0] b, logic [4:0] d);
        instr_t r;
        r.op    = op;
        r.src_a = a;
        r.src_b = b;
        r.dst   = d[3:0];
        return r;
    endfunction

    // micro program: initialization, tracking step, result conversion
    function automatic instr_t prog_fetch(logic [5:0] pc);
        instr_t r;
        unique case (pc)
            6'd0:  r = ins(OP_MUL,   SRC_OW,  SRC_W,    R_A);
            6'd1:  r = ins(OP_MUL,   R_A,     R_A,      R_A);
            6'd2:  r = ins(OP_MUL,   SRC_PW,  SRC_W,    R_U);
            6'd3:  r = ins(OP_MUL,   R_U,     R_U,      R_U);
            6'd4:  r = ins(OP_ADD,   R_A,     R_U,      R_VWW);
            6'd5:  r = ins(OP_MUL,   SRC_PT,  SRC_T0,   R_T7);
            6'd6:  r = ins(OP_MUL,   R_T7,    R_T7,     R_T7);
            6'd7:  r = ins(OP_MUL,   SRC_OC,  SRC_T0,   R_T8);
            6'd8:  r = ins(OP_MUL,   R_T8,    R_T8,     R_T8);
            6'd9:  r = ins(OP_ADD,   R_T7,    R_T8,     R_VTT);
            6'd10: r = ins(OP_ADD,   SRC_ZERO, SRC_ZERO, R_VWT);
            6'd11: r = ins(OP_CLAMP, SRC_W,   SRC_ZERO, R_EW);
            6'd12: r = ins(OP_CLAMP, SRC_T0,  SRC_ZERO, R_ET);
            6'd13: r = ins(OP_JOUT,  SRC_ZERO, SRC_ZERO, R_EW);
            // tracking step
            6'd14: r = ins(OP_DIV,   SRC_DT,  SRC_K,    R_A);
            6'd15: r = ins(OP_MUL,   R_A,     SRC_AVG,  R_U);
            6'd16: r = ins(OP_MUL,   SRC_PW,  SRC_WF,   R_T7);
            6'd17: r = ins(OP_MUL,   R_T7,    R_T7,     R_T7);
            6'd18: r = ins(OP_MUL,   R_U,     SRC_OC,   R_T8);
            6'd19: r = ins(OP_MUL,   R_T8,    R_T8,     R_T8);
            6'd20: r = ins(OP_ADD,   R_T7,    R_T8,     R_T7);
            6'd21: r = ins(OP_MUL,   R_A,     R_VTT,    R_P01);
            6'd22: r = ins(OP_SUB,   R_VWT,   R_P01,    R_P01);
            6'd23: r = ins(OP_MUL,   R_A,     R_VWT,    R_P00);
            6'd24: r = ins(OP_SUB,   R_VWW,   R_P00,    R_P00);
            6'd25: r = ins(OP_MUL,   R_A,     R_P01,    R_S);
            6'd26: r = ins(OP_SUB,   R_P00,   R_S,      R_P00);
            6'd27: r = ins(OP_ADD,   R_P00,   R_T7,     R_P00);
            6'd28: r = ins(OP_MUL,   SRC_PT,  SRC_CF,   R_T8);
            6'd29: r = ins(OP_MUL,   R_T8,    R_T8,     R_T8);
            6'd30: r = ins(OP_ADD,   R_VTT,   R_T8,     R_T8);
            6'd31: r = ins(OP_MUL,   SRC_OW,  SRC_W,    R_S);
            6'd32: r = ins(OP_MUL,   R_S,     R_S,      R_S);
            6'd33: r = ins(OP_ADD,   R_P00,   R_S,      R_S);
            6'd34: r = ins(OP_DIV,   R_P00,   R_S,      R_K0);
            6'd35: r = ins(OP_DIV,   R_P01,   R_S,      R_K1);
            6'd36: r = ins(OP_MUL,   R_A,     R_ET,     R_WP);
            6'd37: r = ins(OP_SUB,   R_EW,    R_WP,     R_WP);
            6'd38: r = ins(OP_ADD,   R_WP,    R_U,      R_WP);
            6'd39: r = ins(OP_SUB,   SRC_W,   R_WP,     R_DEL);
            6'd40: r = ins(OP_MUL,   R_K0,    R_DEL,    R_T7);
            6'd41: r = ins(OP_ADD,   R_WP,    R_T7,     R_T7);
            6'd42: r = ins(OP_CLAMP, R_T7,    SRC_ZERO, R_EW);
            6'd43: r = ins(OP_MUL,   R_K1,    R_DEL,    R_T7);
            6'd44: r = ins(OP_ADD,   R_ET,    R_T7,     R_T7);
            6'd45: r = ins(OP_CLAMP, R_T7,    SRC_ZERO, R_ET);
            6'd46: r = ins(OP_MUL,   R_K0,    R_P00,    R_T7);
            6'd47: r = ins(OP_SUB,   R_P00,   R_T7,     R_VWW);
            6'd48: r = ins(OP_MUL,   R_K0,    R_P01,    R_T7);
            6'd49: r = ins(OP_SUB,   R_P01,   R_T7,     R_T7);
            6'd50: r = ins(OP_MUL,   R_K1,    R_P00,    R_A);
            6'd51: r = ins(OP_SUB,   R_P01,   R_A,      R_A);
            6'd52: r = ins(OP_MUL,   R_K1,    R_P01,    R_U);
            6'd53: r = ins(OP_SUB,   R_T8,    R_U,      R_VTT);
            6'd54: r = ins(OP_ADD,   R_T7,    R_A,      R_T7);
            6'd55: r = ins(OP_HALF,  R_T7,    SRC_ZERO, R_VWT);
            // result conversion
            6'd56: r = ins(OP_RNDW,  R_EW,    SRC_ZERO, OUT_EW);
            6'd57: r = ins(OP_RNDT,  R_ET,    SRC_ZERO, OUT_ET);
            6'd58: r = ins(OP_SQRT,  R_VWW,   SRC_ZERO, OUT_SDW);
            6'd59: r = ins(OP_SQRT,  R_VTT,   SRC_ZERO, OUT_SDT);
            default: r = ins(OP_END, SRC_ZERO, SRC_ZERO, R_EW);
        endcase
        return r;
    endfunction

endpackage

// ===== design/tskt_alu.sv =====
// ----------------------------------------------------------------------------
// tskt_alu
// Shared multi-cycle arithmetic unit: Q-format multiply from four 32x32
// partial products, restoring divide one bit a cycle, integer square root
// one bit pair a cycle, and direct saturating add, clamp and rounding.
// ----------------------------------------------------------------------------
module tskt_alu
    import tskt_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  alu_req_t    req,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output alu_rsp_t    rsp,
    output logic [63:0] res
);

    localparam logic [127:0] RND_HALF = 128'(1) << (FRAC_BITS - 1);
    localparam logic [64:0]  INT_HALF = 65'(1) << (FRAC_BITS - 1);

    alu_state_t   state_reg, state_next;
    op_t          op_reg, op_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic [127:0] n_reg, n_next;
    logic [63:0]  x_reg, x_next;
    logic [63:0]  y_reg, y_next;
    logic [63:0]  r_reg, r_next;
    logic [63:0]  q_reg, q_next;
    logic         neg_reg, neg_next;
    logic         ovf_reg, ovf_next;
    logic [63:0]  res_reg, res_next;
    logic         done_reg, done_next;

    logic [63:0]  a_mag, b_mag;
    logic [31:0]  pp_x, pp_y;
    logic [63:0]  pp;
    logic [6:0]   pp_sh;
    logic [63:0]  div_rs;
    logic         div_ge;
    logic [63:0]  sq_bit, sq_try;
    logic         sq_ge;
    logic [64:0]  rnd_sum;
    logic [63:0]  rnd_mag;
    logic [63:0]  half_sum;
    logic [63:0]  sq_out;

    function automatic logic [63:0] sat_signed(logic [63:0] m, logic neg);
        logic [63:0] r;
        r = (m > SMAX) ? SMAX : m;
        return neg ? (64'd0 - r) : r;
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] x, logic [63:0] y);
        logic [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (y == 64'd0) begin
            return x;
        end
        if ($signed(s) > $signed({1'b0, SMAX})) begin
            return SMAX;
        end
        if ($signed(s) < $signed({1'b1, NEG_SMAX})) begin
            return NEG_SMAX;
        end
        return s[63:0];
    endfunction

    // operand magnitudes and per-cycle datapath pieces
    always_comb
    begin
        a_mag    = a[63] ? (64'd0 - a) : a;
        b_mag    = b[63] ? (64'd0 - b) : b;
        pp_x     = cnt_reg[0] ? x_reg[63:32] : x_reg[31:0];
        pp_y     = cnt_reg[1] ? y_reg[63:32] : y_reg[31:0];
        pp       = 64'(pp_x) * 64'(pp_y);
        pp_sh    = 7'(({6'd0, cnt_reg[0]} + {6'd0, cnt_reg[1]}) << 5);
        div_rs   = {r_reg[62:0], n_reg[127]};
        div_ge   = div_rs >= y_reg;
        sq_bit   = 64'(1) << (6'd62 - {cnt_reg[4:0], 1'b0});
        sq_try   = q_reg + sq_bit;
        sq_ge    = r_reg >= sq_try;
        rnd_sum  = {1'b0, a_mag} + INT_HALF;
        rnd_mag  = 64'(rnd_sum >> FRAC_BITS);
        half_sum = a + {63'd0, a[63]};
        sq_out   = (q_reg + 64'd1) >> 1;
    end

    // unit sequencing
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            AL_IDLE:
            begin
                if (req.start) begin
                    op_next = req.op;
                    case (req.op)
                        OP_MUL:
                        begin
                            x_next     = a_mag;
                            y_next     = b_mag;
                            neg_next   = a[63] ^ b[63];
                            n_next     = '0;
                            cnt_next   = '0;
                            state_next = AL_MUL;
                        end
                        OP_DIV:
                        begin
                            if ($signed(b) <= 0) begin
                                res_next  = '0;
                                done_next = 1'b1;
                            end else begin
                                y_next     = b;
                                neg_next   = a[63];
                                n_next     = (128'(a_mag) << FRAC_BITS) + 128'(b >> 1);
                                r_next     = '0;
                                q_next     = '0;
                                ovf_next   = 1'b0;
                                cnt_next   = '0;
                                state_next = AL_DIV;
                            end
                        end
                        OP_SQRT:
                        begin
                            if ($signed(a) <= 0) begin
                                res_next  = '0;
                                done_next = 1'b1;
                            end else begin
                                r_next     = a >> (FRAC_BITS - 2);
                                q_next     = '0;
                                cnt_next   = '0;
                                state_next = AL_SQRT;
                            end
                        end
                        OP_ADD:
                        begin
                            res_next  = sat_add(a, b);
                            done_next = 1'b1;
                        end
                        OP_SUB:
                        begin
                            res_next  = sat_add(a, (b == SMIN) ? SMAX : (64'd0 - b));
                            done_next = 1'b1;
                        end
                        OP_CLAMP:
                        begin
                            if ($signed(a) > $signed(EST_LIM)) begin
                                res_next = EST_LIM;
                            end else if ($signed(a) < -$signed(EST_LIM)) begin
                                res_next = 64'd0 - EST_LIM;
                            end else begin
                                res_next = a;
                            end
                            done_next = 1'b1;
                        end
                        OP_HALF:
                        begin
                            res_next  = {half_sum[63], half_sum[63:1]};
                            done_next = 1'b1;
                        end
                        OP_RNDW:
                        begin
                            if (a[63]) begin
                                res_next = '0;
                            end else begin
                                res_next = (rnd_mag > 64'd65535) ? 64'd65535 : rnd_mag;
                            end
                            done_next = 1'b1;
                        end
                        OP_RNDT:
                        begin
                            if (!a[63]) begin
                                res_next = (rnd_mag > 64'd32767) ? 64'd32767 : rnd_mag;
                            end else begin
                                res_next = (rnd_mag > 64'd32768) ? (64'd0 - 64'd32768)
                                                                 : (64'd0 - rnd_mag);
                            end
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            res_next  = '0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            AL_MUL:
            begin
                // four partial products, then the rounding add
                if (cnt_reg < 8'd4) begin
                    n_next   = n_reg + (128'(pp) << pp_sh);
                    cnt_next = cnt_reg + 8'd1;
                end else begin
                    n_next     = n_reg + RND_HALF;
                    state_next = AL_FIN;
                end
            end
            AL_DIV:
            begin
                n_next   = n_reg << 1;
                r_next   = div_ge ? (div_rs - y_reg) : div_rs;
                q_next   = {q_reg[62:0], div_ge};
                if (div_ge && (cnt_reg[7:6] == 2'b00)) begin
                    ovf_next = 1'b1;
                end
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == 8'd127) begin
                    state_next = AL_FIN;
                end
            end
            AL_SQRT:
            begin
                if (sq_ge) begin
                    r_next = r_reg - sq_try;
                    q_next = (q_reg >> 1) + sq_bit;
                end else begin
                    q_next = q_reg >> 1;
                end
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == 8'd31) begin
                    state_next = AL_FIN;
                end
            end
            AL_FIN:
            begin
                done_next  = 1'b1;
                state_next = AL_IDLE;
                case (op_reg)
                    OP_MUL:
                    begin
                        res_next = sat_signed((|n_reg[127:64+FRAC_BITS]) ? SMAX
                                              : n_reg[63+FRAC_BITS:FRAC_BITS], neg_reg);
                    end
                    OP_DIV:
                    begin
                        res_next = sat_signed(ovf_reg ? SMAX : q_reg, neg_reg);
                    end
                    OP_SQRT:
                    begin
                        res_next = (sq_out > 64'd65535) ? 64'd65535 : sq_out;
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            default:
            begin
                state_next = AL_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= AL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        n_reg   <= n_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign res      = res_reg;

endmodule

// ===== design/two_state_kalman_tracker_core.sv =====
// ----------------------------------------------------------------------------
// two_state_kalman_tracker_core
// Forward two-state Kalman filter for body weight and daily expenditure.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word on s_* is one log entry (day gap, weight, calories); each
//   produces one output word on m_* with both estimates and their standard
//   deviations. The first word after reset seeds the state, later words run
//   predict and correct.
//   A micro program steps one shared arithmetic unit over a 16-entry register
//   file. A divide works through 128 quotient bits and a square root through
//   bit pairs; add, subtract, clamp and rounding do not iterate, nor do a
//   divide by a nonpositive divisor and a root of a nonpositive value. Later
//   words spend most of their work in the three divides; the next word can
//   be taken in the cycle after the result is loaded. s_tready is high only
//   while no word is in work. A finished word sits in the output register;
//   the core takes a new input word while it waits, but cannot hand over the
//   next result until the receiver takes the first (m_tvalid holds data
//   stable under backpressure). Reset clears the filter state, so the next
//   word seeds it again, and loads the configuration defaults.
//   Configuration is written through cfg_we, cfg_index and cfg_data while the
//   core is idle; the user must keep to this, the core does not enforce it.
// ----------------------------------------------------------------------------
module two_state_kalman_tracker_core
    import tskt_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] day_gap, [25:10] weight, [40:26] calories, [47:41] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] est_weight, [31:16] est_tdee, [47:32] sd_weight, [63:48] sd_tdee
    output logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    seq_state_t  state_reg, state_next;
    logic [5:0]  pc_reg, pc_next;
    logic        started_reg, started_next;
    logic [14:0] last_cal_reg, last_cal_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg;
    logic        out_load;

    logic [15:0] cpk_reg, ow_reg, oc_reg, pw_reg, pt_reg;
    logic [14:0] init_reg;

    logic [9:0]  dt_reg;
    logic [15:0] w_reg;
    logic [14:0] c_reg;

    logic [63:0] rf_mem [16];
    logic [63:0] rd_a_reg, rd_b_reg;
    logic        rf_we;
    logic        fld_we;
    logic [15:0] fld_reg [4];

    instr_t      instr;
    spec_t       spec;
    logic [63:0] op_a, op_b;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    logic [63:0] alu_res;
    logic        in_accept;

    function automatic logic [63:0] pick(spec_t s, logic [4:0] code, logic [63:0] rd);
        logic [63:0] v;
        unique case (code)
            SRC_W:   v = s.w;
            SRC_T0:  v = s.t0;
            SRC_OW:  v = s.ow;
            SRC_OC:  v = s.oc;
            SRC_PW:  v = s.pw;
            SRC_PT:  v = s.pt;
            SRC_WF:  v = s.wf;
            SRC_CF:  v = s.cf;
            SRC_AVG: v = s.avg;
            SRC_DT:  v = s.dt;
            SRC_K:   v = s.k;
            default: v = code[4] ? 64'd0 : rd;
        endcase
        return v;
    endfunction

    assign in_accept = s_tvalid && s_tready;
    assign instr     = prog_fetch(pc_reg);

    // operands derived from the word and the configuration
    always_comb
    begin
        spec.w   = 64'(w_reg) << FRAC_BITS;
        spec.t0  = 64'((init_reg != 15'd0) ? init_reg : c_reg) << FRAC_BITS;
        spec.ow  = 64'(ow_reg) << (FRAC_BITS - 16);
        spec.oc  = 64'(oc_reg) << (FRAC_BITS - 16);
        spec.pw  = 64'(pw_reg) << (FRAC_BITS - 16);
        spec.pt  = 64'(pt_reg) << (FRAC_BITS - 16);
        spec.wf  = 64'((w_reg > WEIGHT_FLOOR) ? w_reg : WEIGHT_FLOOR) << FRAC_BITS;
        spec.cf  = 64'((c_reg > CAL_FLOOR) ? c_reg : CAL_FLOOR) << FRAC_BITS;
        spec.avg = 64'({1'b0, last_cal_reg} + {1'b0, c_reg}) << (FRAC_BITS - 1);
        spec.dt  = 64'(dt_reg) * 64'd100;
        spec.k   = 64'((cpk_reg != 16'd0) ? cpk_reg : 16'd1);
        op_a     = pick(spec, instr.src_a, rd_a_reg);
        op_b     = pick(spec, instr.src_b, rd_b_reg);
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        started_next  = started_reg;
        last_cal_next = last_cal_reg;
        alu_req.start = 1'b0;
        alu_req.op    = instr.op;
        rf_we         = 1'b0;
        fld_we        = 1'b0;
        out_load      = 1'b0;
        s_tready      = 1'b0;
        unique case (state_reg)
            SQ_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    pc_next    = started_reg ? STEP_START : 6'd0;
                    state_next = SQ_FETCH;
                end
            end
            SQ_FETCH:
            begin
                case (instr.op)
                    OP_JOUT:
                    begin
                        pc_next = OUT_START;
                    end
                    OP_END:
                    begin
                        started_next  = 1'b1;
                        last_cal_next = c_reg;
                        state_next    = SQ_DONE;
                    end
                    default:
                    begin
                        state_next = SQ_ISSUE;
                    end
                endcase
            end
            SQ_ISSUE:
            begin
                alu_req.start = 1'b1;
                state_next    = SQ_WAIT;
            end
            SQ_WAIT:
            begin
                if (alu_rsp.done) begin
                    case (instr.op) inside
                        OP_RNDW, OP_RNDT, OP_SQRT: fld_we = 1'b1;
                        default:                   rf_we  = 1'b1;
                    endcase
                    pc_next    = pc_reg + 6'd1;
                    state_next = SQ_FETCH;
                end
            end
            SQ_DONE:
            begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= SQ_IDLE;
            pc_reg       <= '0;
            started_reg  <= 1'b0;
            last_cal_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            started_reg  <= started_next;
            last_cal_reg <= last_cal_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cpk_reg  <= 16'd7700;
            ow_reg   <= 16'd524;
            oc_reg   <= 16'd6554;
            pw_reg   <= 16'd7;
            pt_reg   <= 16'd655;
            init_reg <= 15'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CAL_PER_FAT_KG:    cpk_reg  <= cfg_data;
                CFG_OBS_WEIGHT_NOISE:  ow_reg   <= cfg_data;
                CFG_OBS_CAL_NOISE:     oc_reg   <= cfg_data;
                CFG_PROC_WEIGHT_NOISE: pw_reg   <= cfg_data;
                CFG_PROC_TDEE_NOISE:   pt_reg   <= cfg_data;
                CFG_INITIAL_TDEE:      init_reg <= cfg_data[14:0];
                default:               ;
            endcase
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            dt_reg <= s_tdata[9:0];
            w_reg  <= s_tdata[25:10];
            c_reg  <= s_tdata[40:26];
        end
    end

    // register file, registered reads
    always_ff @(posedge clk)
    begin
        rd_a_reg <= rf_mem[instr.src_a[3:0]];
        rd_b_reg <= rf_mem[instr.src_b[3:0]];
        if (rf_we) begin
            rf_mem[instr.dst] <= alu_res;
        end
    end

    // result fields and output word
    always_ff @(posedge clk)
    begin
        if (fld_we) begin
            fld_reg[instr.dst[1:0]] <= alu_res[15:0];
        end
        if (out_load) begin
            m_tdata_reg <= {fld_reg[3], fld_reg[2], fld_reg[1], fld_reg[0]};
        end
    end

    tskt_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (op_a),
        .b     (op_b),
        .rsp   (alu_rsp),
        .res   (alu_res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/tskt_checker.sv =====
// ----------------------------------------------------------------------------
// tskt_checker
// Port-level checks of the tracker core, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_state_kalman_tracker_core_defines.svh"

module tskt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // stalled output word holds
    `TSKT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed under stall")

    // core is busy right after taking a word
    `TSKT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")

    // a new result only appears from a busy core
    `TSKT_ASSERT_SAME(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result without work")

endmodule

bind two_state_kalman_tracker_core tskt_checker u_tskt_checker (.*);
